@@ sv/slcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the sync/length/checksum deframer.
// Used by slcd_ring and sync_length_checksum_deframer; no dependencies.
package slcd_pkg;

    localparam int RING_DEPTH    = 256;
    localparam int RING_AW       = $clog2(RING_DEPTH);
    localparam int FILL_W        = $clog2(RING_DEPTH + 1);
    localparam int MAX_FRAME_LEN = 64;
    // offsets into a candidate reach MAX_FRAME_LEN + 3 bytes past the head
    localparam int OFF_W         = $clog2(MAX_FRAME_LEN + 4 + 1);
    localparam int MAXLEN_W      = 7;

    localparam logic [7:0] SYNC_HEAD = 8'h55;
    localparam logic [7:0] SYNC_TAIL = 8'hAA;
    localparam int         MIN_HELD  = 4;
    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = MAXLEN_W'(64);

    // Requests from the sequencer to the ring
    typedef struct packed {
        logic             push;
        logic [7:0]       push_byte;
        logic             drop;
        logic [OFF_W-1:0] drop_cnt;
        logic [OFF_W-1:0] rd_off;
    } slcd_ring_ctrl_t;

endpackage

@@ sv/slcd_ring.sv @@
`timescale 1ns / 1ps
// Byte ring: 256-entry memory with head pointer and fill count.
// One write port at the tail, one registered read port at head + offset.
// Depends on slcd_pkg.
module slcd_ring (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  slcd_pkg::slcd_ring_ctrl_t     ctrl,
    output logic [slcd_pkg::FILL_W-1:0]   fill,
    output logic [7:0]                    rd_data
);
    import slcd_pkg::*;

    logic [7:0]         ring_mem [RING_DEPTH];
    logic [RING_AW-1:0] head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [7:0]         rd_data_reg;
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;
    logic [RING_AW-1:0] rd_addr;

    assign wr_en   = ctrl.push && (fill_reg < FILL_W'(RING_DEPTH));
    assign wr_addr = head_reg + fill_reg[RING_AW-1:0];
    assign rd_addr = head_reg + RING_AW'(ctrl.rd_off);

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (wr_en) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (ctrl.drop) begin
            head_next = head_reg + RING_AW'(ctrl.drop_cnt);
            fill_next = fill_reg - FILL_W'(ctrl.drop_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= ctrl.push_byte;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    assign fill    = fill_reg;
    assign rd_data = rd_data_reg;

endmodule

@@ sv/sync_length_checksum_deframer.sv @@
`timescale 1ns / 1ps
// Deframer top level: scan sequencer, checksum accumulator and result register.
// Depends on slcd_pkg and slcd_ring.
//
// Each accepted transaction may append one byte to a 256-byte ring and then runs one
// scan step at the head: a non-0x55 head or a malformed candidate (length 0 or above
// max_length, bad 0xAA tail, bad additive checksum) drops one byte; an incomplete
// candidate waits; a valid frame 0x55, L, L body bytes, sum, 0xAA is removed and given
// out as one result per data byte (one result for a command-only frame). The input
// is not ready while a step runs. A step ends at the first head, length or tail check
// that stops it, or walks the whole checksum, and a valid frame also waits on any output
// stall: the single ring read port delivers one byte per cycle while the checksum is
// walked, the byte-wide adder sums one per cycle and each data byte then passes
// through a load state and an output state.
module sync_length_checksum_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [slcd_pkg::MAXLEN_W-1:0]  cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_byte_present,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_command,
    output logic [7:0]                     m_data_byte,
    output logic                           m_data_valid,
    output logic                           m_last
);
    import slcd_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SCAN = 8'b0000_0010,
        ST_HEAD = 8'b0000_0100,
        ST_LEN  = 8'b0000_1000,
        ST_TAIL = 8'b0001_0000,
        ST_SUM  = 8'b0010_0000,
        ST_LOAD = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } slcd_state_t;

    slcd_state_t          state_reg, state_next;
    logic [MAXLEN_W-1:0]  max_len_reg;
    logic [OFF_W-1:0]     len_reg, len_next;
    logic [OFF_W-1:0]     k_reg, k_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_command_reg, m_command_next;
    logic [7:0]           m_data_reg, m_data_next;
    logic                 m_dvalid_reg, m_dvalid_next;
    logic                 m_last_reg, m_last_next;

    slcd_ring_ctrl_t      ring_ctrl;
    logic [FILL_W-1:0]    fill;
    logic [7:0]           rd_data;
    logic                 len_bad;

    slcd_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ring_ctrl),
        .fill    (fill),
        .rd_data (rd_data)
    );

    assign len_bad = (rd_data == 8'd0) || (rd_data > {1'b0, max_len_reg})
                     || (rd_data > 8'(MAX_FRAME_LEN));

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        cmd_next       = cmd_reg;
        m_valid_next   = m_valid_reg;
        m_command_next = m_command_reg;
        m_data_next    = m_data_reg;
        m_dvalid_next  = m_dvalid_reg;
        m_last_next    = m_last_reg;
        ring_ctrl           = '0;
        ring_ctrl.push_byte = s_rx_byte;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ring_ctrl.push = s_byte_present;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ring_ctrl.rd_off = '0;
                state_next = (fill == '0) ? ST_IDLE : ST_HEAD;
            end
            ST_HEAD: begin
                if (rd_data != SYNC_HEAD) begin
                    ring_ctrl.drop     = 1'b1;
                    ring_ctrl.drop_cnt = OFF_W'(1);
                    state_next         = ST_IDLE;
                end else if (fill < FILL_W'(MIN_HELD)) begin
                    state_next = ST_IDLE;
                end else begin
                    ring_ctrl.rd_off = OFF_W'(1);
                    state_next       = ST_LEN;
                end
            end
            ST_LEN: begin
                len_next = rd_data[OFF_W-1:0];
                if (len_bad) begin
                    ring_ctrl.drop     = 1'b1;
                    ring_ctrl.drop_cnt = OFF_W'(1);
                    state_next         = ST_IDLE;
                end else if (fill < FILL_W'(rd_data) + FILL_W'(MIN_HELD)) begin
                    state_next = ST_IDLE;
                end else begin
                    ring_ctrl.rd_off = rd_data[OFF_W-1:0] + OFF_W'(3);
                    state_next       = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (rd_data != SYNC_TAIL) begin
                    ring_ctrl.drop     = 1'b1;
                    ring_ctrl.drop_cnt = OFF_W'(1);
                    state_next         = ST_IDLE;
                end else begin
                    ring_ctrl.rd_off = OFF_W'(2);
                    k_next           = '0;
                    sum_next         = '0;
                    state_next       = ST_SUM;
                end
            end
            ST_SUM: begin
                if (k_reg == len_reg) begin
                    // rd_data is the checksum byte
                    if (sum_reg != rd_data) begin
                        ring_ctrl.drop     = 1'b1;
                        ring_ctrl.drop_cnt = OFF_W'(1);
                        state_next         = ST_IDLE;
                    end else if (len_reg == OFF_W'(1)) begin
                        m_valid_next   = 1'b1;
                        m_command_next = cmd_reg;
                        m_data_next    = '0;
                        m_dvalid_next  = 1'b0;
                        m_last_next    = 1'b1;
                        state_next     = ST_OUT;
                    end else begin
                        ring_ctrl.rd_off = OFF_W'(3);
                        k_next           = OFF_W'(1);
                        state_next       = ST_LOAD;
                    end
                end else begin
                    sum_next = sum_reg + rd_data;
                    if (k_reg == '0) begin
                        cmd_next = rd_data;
                    end
                    k_next           = k_reg + OFF_W'(1);
                    ring_ctrl.rd_off = k_reg + OFF_W'(3);
                end
            end
            ST_LOAD: begin
                m_valid_next   = 1'b1;
                m_command_next = cmd_reg;
                m_data_next    = rd_data;
                m_dvalid_next  = 1'b1;
                m_last_next    = (k_reg + OFF_W'(1) == len_reg);
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        // remove the whole frame
                        ring_ctrl.drop     = 1'b1;
                        ring_ctrl.drop_cnt = len_reg + OFF_W'(MIN_HELD);
                        state_next         = ST_IDLE;
                    end else begin
                        k_next           = k_reg + OFF_W'(1);
                        ring_ctrl.rd_off = k_reg + OFF_W'(3);
                        state_next       = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            max_len_reg <= MAX_LENGTH_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg       <= len_next;
        k_reg         <= k_next;
        sum_reg       <= sum_next;
        cmd_reg       <= cmd_next;
        m_command_reg <= m_command_next;
        m_data_reg    <= m_data_next;
        m_dvalid_reg  <= m_dvalid_next;
        m_last_reg    <= m_last_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_command    = m_command_reg;
    assign m_data_byte  = m_data_reg;
    assign m_data_valid = m_dvalid_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("scan step did not start after transaction");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid))
        else $error("sequencer not idle after final result of frame");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill <= FILL_W'(RING_DEPTH))
        else $error("ring fill count beyond depth");
`endif

endmodule
